// ===== rtl/core/imhck_pkg.sv =====
`timescale 1ns / 1ps
package imhck_pkg;
   localparam int Capacity = 1024;
   localparam int SlotBits = 10;
   localparam int CountBits = 11;
   localparam int IdBits = 10;
   localparam int KeyBits = 32;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP = 2'd1;
   localparam logic [1:0] OP_CHANGE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_START, S_GET_OWN, S_RD_PAIR, S_UP_CMP, S_RD_KIDS,
      S_DN_CMP, S_FIX_MAP, S_DONE
   } state_type;

   typedef struct packed {
      logic [KeyBits-1:0] key;
      logic [IdBits-1:0] id;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic [SlotBits-1:0] slot;
   } pos_type;

   function automatic logic [KeyBits-1:0] sat_add(input logic [KeyBits-1:0] a,
                                                   input logic [KeyBits-1:0] d);
      logic [KeyBits:0] s;
      s = {a[KeyBits-1], a} + {d[KeyBits-1], d};
      if (s[KeyBits] != s[KeyBits-1])
         sat_add = s[KeyBits] ? {1'b1, {(KeyBits-1){1'b0}}} : {1'b0, {(KeyBits-1){1'b1}}};
      else
         sat_add = s[KeyBits-1:0];
   endfunction
endpackage

// ===== rtl/core/indexed_min_heap_change_key.sv =====
`timescale 1ns / 1ps
// Indexed min-heap of (id, key) pairs with an id-to-slot position map.
// Request channel (req_valid/req_ready): op 0 push, 1 pop, 2 add a signed
// delta to the key of id. Response channel (rsp_valid/rsp_ready): status,
// popped id and key, and the entry count after the operation.
// One request is in flight at a time. The map lookup and the first slot
// reads come first; each level of sifting is a registered read of the
// parent or of both children, then a compare with a write-back of the
// moved entry and of its map entry, over at most the 10 levels of the heap.
// The entry is then placed and the response loaded; a rejected or unused
// request skips sifting and placing. req_ready rises the cycle after the
// response is loaded, so a new request is taken only once the response
// of the last one has been loaded.
// After reset the block sweeps the position map, marking all 1024 ids
// absent; req_ready stays low during that sweep.
// A finished response is held in the output register until taken; while
// rsp_valid waits, the next request is accepted and processed up to its
// own response, which then waits for the register to free.
module indexed_min_heap_change_key
   import imhck_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic [IdBits-1:0]        req_id,
   input  logic signed [KeyBits-1:0] req_key_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [IdBits-1:0]        rsp_out_id,
   output logic signed [KeyBits-1:0] rsp_out_key,
   output logic [CountBits-1:0]     rsp_count
);
   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [IdBits-1:0] id_ff, id_in;
   logic [KeyBits-1:0] val_ff, val_in;
   logic [CountBits-1:0] fill_ff, fill_in;
   logic [SlotBits-1:0] cur_ff, cur_in;     // hole where the moving entry goes
   entry_type ent_ff, ent_in;               // moving entry
   logic [IdBits-1:0] clr_ff, clr_in;
   logic [1:0] st_ff, st_in;
   logic [IdBits-1:0] oid_ff, oid_in;
   logic [KeyBits-1:0] okey_ff, okey_in;
   logic rv_ff, rv_in;
   logic [1:0] rs_ff, rs_in;
   logic [IdBits-1:0] ri_ff, ri_in;
   logic [KeyBits-1:0] rk_ff, rk_in;
   logic [CountBits-1:0] rc_ff, rc_in;

   logic s_we;
   logic [SlotBits-1:0] s_wa, s_ra, s_rb;
   entry_type s_wd, s_da, s_db;
   logic p_we;
   logic [IdBits-1:0] p_wa, p_ra;
   pos_type p_wd, p_rd;

   imhck_slot_ram u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr_a(s_ra), .rd_addr_b(s_rb), .rd_data_a(s_da), .rd_data_b(s_db)
   );
   imhck_pos_ram u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   logic [SlotBits-1:0] parent, lkid, rkid;
   logic [CountBits:0] lk_w;
   logic lk_ok, rk_ok, pick_r, l_less, r_less, up_move;
   logic [SlotBits-1:0] last;
   entry_type kid;

   always_comb begin
      parent = (cur_ff - SlotBits'(1)) >> 1;
      lk_w = {1'b0, cur_ff, 1'b1};
      lkid = lk_w[SlotBits-1:0];
      rkid = lkid + SlotBits'(1);
      lk_ok = lk_w < {1'b0, fill_ff};
      rk_ok = (lk_w + (CountBits+1)'(1)) < {1'b0, fill_ff};
      last = SlotBits'(fill_ff - CountBits'(1));
      l_less = lk_ok && ($signed(s_da.key) < $signed(ent_ff.key));
      r_less = rk_ok && ($signed(s_db.key) < $signed(l_less ? s_da.key : ent_ff.key));
      pick_r = r_less;
      kid = pick_r ? s_db : s_da;
      up_move = $signed(ent_ff.key) < $signed(s_da.key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         fill_ff <= '0;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in; id_ff <= id_in; val_ff <= val_in;
      cur_ff <= cur_in; ent_ff <= ent_in;
      st_ff <= st_in; oid_ff <= oid_in; okey_ff <= okey_in;
      rs_ff <= rs_in; ri_ff <= ri_in; rk_ff <= rk_in; rc_ff <= rc_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE: if (req_valid) state_in = S_LOOK;
         S_LOOK: state_in = S_START;
         S_START: begin
            state_in = S_DONE;
            case (op_ff)
               OP_PUSH:
                  if (!(fill_ff >= CountBits'(Capacity) || p_rd.valid))
                     state_in = S_RD_PAIR;
               OP_POP:
                  if (fill_ff > CountBits'(1)) state_in = S_RD_KIDS;
               OP_CHANGE:
                  if (p_rd.valid) state_in = S_GET_OWN;
               default: state_in = S_DONE;
            endcase
         end
         S_GET_OWN:
            state_in = (!val_ff[KeyBits-1] && (val_ff != '0)) ? S_RD_KIDS : S_RD_PAIR;
         S_RD_PAIR: state_in = (cur_ff == '0) ? S_FIX_MAP : S_UP_CMP;
         S_UP_CMP: state_in = up_move ? S_RD_PAIR : S_FIX_MAP;
         S_RD_KIDS: state_in = S_DN_CMP;
         S_DN_CMP: state_in = (l_less || r_less) ? S_RD_KIDS : S_FIX_MAP;
         S_FIX_MAP: state_in = S_DONE;
         S_DONE: if (!rv_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in = op_ff; id_in = id_ff; val_in = val_ff;
      fill_in = fill_ff; clr_in = clr_ff;
      cur_in = cur_ff; ent_in = ent_ff;
      st_in = st_ff; oid_in = oid_ff; okey_in = okey_ff;
      rv_in = rv_ff; rs_in = rs_ff; ri_in = ri_ff; rk_in = rk_ff; rc_in = rc_ff;
      req_ready = 1'b0;
      s_we = 1'b0; s_wa = cur_ff; s_wd = ent_ff;
      s_ra = parent; s_rb = rkid;
      p_we = 1'b0; p_wa = ent_ff.id; p_wd = '{valid: 1'b1, slot: cur_ff};
      p_ra = id_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            p_we = 1'b1; p_wa = clr_ff; p_wd = '0;
            clr_in = clr_ff + IdBits'(1);
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_op; id_in = req_id; val_in = req_key_value;
               st_in = ST_OK; oid_in = '0; okey_in = '0;
            end
         end
         S_LOOK: begin
            // fetch root and last entry for a pop
            s_ra = '0; s_rb = last;
         end
         S_START: begin
            s_ra = p_rd.slot;
            case (op_ff)
               OP_PUSH:
                  if (fill_ff >= CountBits'(Capacity) || p_rd.valid) st_in = ST_FULL;
                  else begin
                     cur_in = SlotBits'(fill_ff);
                     ent_in = '{key: val_ff, id: id_ff};
                     fill_in = fill_ff + CountBits'(1);
                  end
               OP_POP:
                  if (fill_ff == '0) st_in = ST_EMPTY;
                  else begin
                     oid_in = s_da.id; okey_in = s_da.key;
                     fill_in = fill_ff - CountBits'(1);
                     ent_in = s_db; cur_in = '0;
                  end
               OP_CHANGE:
                  if (!p_rd.valid) st_in = ST_ABSENT;
                  else cur_in = p_rd.slot;
               default: st_in = ST_OK;
            endcase
         end
         S_GET_OWN: ent_in = '{key: sat_add(s_da.key, val_ff), id: id_ff};
         S_RD_PAIR: s_ra = parent;
         S_UP_CMP: begin
            if (up_move) begin
               // move parent down into the hole
               s_we = 1'b1; s_wd = s_da;
               p_we = 1'b1; p_wa = s_da.id; p_wd = '{valid: 1'b1, slot: cur_ff};
               cur_in = parent;
            end
         end
         S_RD_KIDS: begin
            s_ra = lkid; s_rb = rkid;
         end
         S_DN_CMP: begin
            if (l_less || r_less) begin
               // move the smaller child up into the hole
               s_we = 1'b1; s_wd = kid;
               p_we = 1'b1; p_wa = kid.id; p_wd = '{valid: 1'b1, slot: cur_ff};
               cur_in = pick_r ? rkid : lkid;
            end
         end
         S_FIX_MAP: begin
            s_we = 1'b1;
            p_we = 1'b1;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1; rs_in = st_ff; ri_in = oid_ff; rk_in = okey_ff;
               rc_in = fill_ff;
               if (op_ff == OP_POP && st_ff == ST_OK) begin
                  p_we = 1'b1; p_wa = oid_ff; p_wd = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_out_id = ri_ff;
   assign rsp_out_key = rk_ff;
   assign rsp_count = rc_ff;

`ifndef NO_ASSERTIONS
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CountBits'(Capacity)) else $error("fill above capacity");
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready) else $error("ready during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff) else $error("response dropped");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
`endif
endmodule

// ===== rtl/core/imhck_slot_ram.sv =====
`timescale 1ns / 1ps
module imhck_slot_ram
   import imhck_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SlotBits-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic [SlotBits-1:0] rd_addr_a,
   input  logic [SlotBits-1:0] rd_addr_b,
   output entry_type           rd_data_a,
   output entry_type           rd_data_b
);
   entry_type mem [Capacity];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

// ===== rtl/core/imhck_pos_ram.sv =====
`timescale 1ns / 1ps
module imhck_pos_ram
   import imhck_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IdBits-1:0] wr_addr,
   input  pos_type           wr_data,
   input  logic [IdBits-1:0] rd_addr,
   output pos_type           rd_data
);
   pos_type mem [1 << IdBits];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== verif/indexed_min_heap_change_key_tb.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_change_key_tb;
   import imhck_pkg::*;

   localparam int WatchdogLimit = 6000;
   localparam int LongHold = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [KeyBits-1:0] KeyMax = {1'b0, {(KeyBits-1){1'b1}}};
   localparam logic signed [KeyBits-1:0] KeyMin = {1'b1, {(KeyBits-1){1'b0}}};

   typedef struct {
      logic [1:0]                status;
      logic [IdBits-1:0]         out_id;
      logic signed [KeyBits-1:0] out_key;
      logic [CountBits-1:0]      count;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_op;
   logic [IdBits-1:0] req_id;
   logic signed [KeyBits-1:0] req_key_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_status;
   logic [IdBits-1:0] rsp_out_id;
   logic signed [KeyBits-1:0] rsp_out_key;
   logic [CountBits-1:0] rsp_count;

   // shadow heap
   logic signed [KeyBits-1:0] heap_key [Capacity];
   logic [IdBits-1:0] heap_id [Capacity];
   logic [SlotBits-1:0] slot_of [1 << IdBits];
   bit present [1 << IdBits];
   int heap_fill;

   heap_result_type pending_results[$];
   int fail_count = 0;
   bit idle_on = 1'b1;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   indexed_min_heap_change_key dut (.*);

   always #6 clock = ~clock;

   function automatic logic signed [KeyBits-1:0] add_saturated(
         logic signed [KeyBits-1:0] a, logic signed [KeyBits-1:0] d);
      logic signed [KeyBits:0] s;
      s = {a[KeyBits-1], a} + {d[KeyBits-1], d};
      if (s > $signed({KeyMax[KeyBits-1], KeyMax}))
         return KeyMax;
      if (s < $signed({KeyMin[KeyBits-1], KeyMin}))
         return KeyMin;
      return s[KeyBits-1:0];
   endfunction

   function automatic void swap_slots(int a, int b);
      logic signed [KeyBits-1:0] k;
      logic [IdBits-1:0] i;
      k = heap_key[a];
      i = heap_id[a];
      heap_key[a] = heap_key[b];
      heap_id[a] = heap_id[b];
      heap_key[b] = k;
      heap_id[b] = i;
      slot_of[heap_id[a]] = SlotBits'(a);
      slot_of[heap_id[b]] = SlotBits'(b);
   endfunction

   function automatic void raise_entry(int n);
      int p;
      while (n != 0) begin
         p = (n - 1) / 2;
         if (!(heap_key[n] < heap_key[p]))
            break;
         swap_slots(n, p);
         n = p;
      end
   endfunction

   function automatic void lower_entry(int n);
      int l;
      int r;
      int s;
      forever begin
         l = 2 * n + 1;
         r = 2 * n + 2;
         s = n;
         if (l < heap_fill && heap_key[l] < heap_key[s])
            s = l;
         if (r < heap_fill && heap_key[r] < heap_key[s])
            s = r;
         if (s == n)
            return;
         swap_slots(n, s);
         n = s;
      end
   endfunction

   function automatic heap_result_type apply_request(logic [1:0] op, logic [IdBits-1:0] id,
                                                      logic signed [KeyBits-1:0] value);
      heap_result_type r;
      int pos;
      r.status = ST_OK;
      r.out_id = '0;
      r.out_key = '0;
      case (op)
         OP_PUSH: begin
            if (heap_fill >= Capacity || present[id]) begin
               r.status = ST_FULL;
            end else begin
               heap_key[heap_fill] = value;
               heap_id[heap_fill] = id;
               slot_of[id] = SlotBits'(heap_fill);
               present[id] = 1'b1;
               heap_fill++;
               raise_entry(heap_fill - 1);
            end
         end
         OP_POP: begin
            if (heap_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.out_key = heap_key[0];
               r.out_id = heap_id[0];
               heap_fill--;
               swap_slots(0, heap_fill);
               present[r.out_id] = 1'b0;
               lower_entry(0);
            end
         end
         OP_CHANGE: begin
            if (!present[id]) begin
               r.status = ST_ABSENT;
            end else begin
               pos = slot_of[id];
               heap_key[pos] = add_saturated(heap_key[pos], value);
               if (value > 0)
                  lower_entry(pos);
               else
                  raise_entry(pos);
            end
         end
         default: ;
      endcase
      r.count = CountBits'(heap_fill);
      return r;
   endfunction

   task automatic send_request(logic [1:0] op, logic [IdBits-1:0] id,
                               logic signed [KeyBits-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_id <= id;
      req_key_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_request(op, id, value));
   endtask

   function automatic logic signed [KeyBits-1:0] random_key();
      case ($urandom_range(0, 5))
         0: return KeyMax;
         1: return KeyMin;
         2: return $signed(KeyBits'($urandom_range(0, 8))) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [IdBits-1:0] present_id();
      if (heap_fill == 0)
         return IdBits'($urandom());
      return heap_id[$urandom_range(0, heap_fill - 1)];
   endfunction

   task automatic send_mixed();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_request(OP_PUSH, IdBits'($urandom()), random_key());
      else if (pick < 70)
         send_request(OP_POP, IdBits'($urandom()), $signed($urandom()));
      else if (pick < 92)
         send_request(OP_CHANGE, present_id(), random_key());
      else if (pick < 97)
         send_request(OP_CHANGE, IdBits'($urandom()), random_key());
      else
         send_request(OP_UNUSED, IdBits'($urandom()), $signed($urandom()));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_corner_cases();
      send_request(OP_POP, 10'd0, 32'sd0);
      send_request(OP_CHANGE, 10'd1023, 32'sd5);
      send_request(OP_PUSH, 10'd1023, KeyMax);
      send_request(OP_PUSH, 10'd0, KeyMin);
      send_request(OP_PUSH, 10'd1023, 32'sd7);
      send_request(OP_PUSH, 10'd5, 32'sd0);
      send_request(OP_PUSH, 10'd6, 32'sd0);
      send_request(OP_PUSH, 10'd7, 32'sd0);
      send_request(OP_CHANGE, 10'd1023, 32'sd1);
      send_request(OP_CHANGE, 10'd0, -32'sd1);
      send_request(OP_CHANGE, 10'd0, KeyMax);
      send_request(OP_CHANGE, 10'd6, 32'sd0);
      send_request(OP_CHANGE, 10'd5, -32'sd1);
      send_request(OP_CHANGE, 10'd7, KeyMin);
      send_request(OP_UNUSED, 10'h3ff, -32'sd1);
      send_request(OP_CHANGE, 10'd512, 32'sd3);
      repeat (6) send_request(OP_POP, 10'h2aa, 32'sh5555aaaa);
      send_request(OP_POP, 10'd0, 32'sd0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_toggle <= ~hold_toggle;
      repeat (20) send_mixed();
      wait_drained();
   endtask

   task automatic test_capacity();
      int order [1 << IdBits];
      int j;
      int t;
      foreach (order[i]) order[i] = i;
      foreach (order[i]) begin
         j = $urandom_range(0, (1 << IdBits) - 1);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i]) send_request(OP_PUSH, IdBits'(order[i]), random_key());
      send_request(OP_PUSH, IdBits'($urandom()), random_key());
      repeat (60) send_request(OP_CHANGE, present_id(), random_key());
      repeat (80) send_request(OP_POP, '0, '0);
      wait_drained();
   endtask

   task automatic test_random_mix();
      repeat (30) send_mixed();
      wait_drained();
   endtask

   task automatic test_no_idling();
      idle_on = 1'b0;
      repeat (40) send_mixed();
      wait_drained();
   endtask

   // receiver: random bursts of stall, plus one long hold on request
   always @(posedge clock) begin
      hold_seen <= hold_toggle;
      if (hold_seen != hold_toggle) begin
         hold_left <= LongHold;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_out_id !== want.out_id) begin
               $display("%0t: out_id expected %0d actual %0d", $time, want.out_id, rsp_out_id);
               fail_count++;
            end
            if (rsp_out_key !== want.out_key) begin
               $display("%0t: out_key expected %0d actual %0d", $time, want.out_key,
                        rsp_out_key);
               fail_count++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_PUSH;
      req_id <= '0;
      req_key_value <= '0;
      heap_fill = 0;
      foreach (present[i]) present[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_backpressure();
      test_capacity();
      test_random_mix();
      test_no_idling();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/imhck_pkg.sv
rtl/core/imhck_slot_ram.sv
rtl/core/imhck_pos_ram.sv
rtl/core/indexed_min_heap_change_key.sv
verif/indexed_min_heap_change_key_tb.sv
